/* src/pcdp_pkg.sv */
// ----------------------------------------------------------------------------
// pcdp_pkg
// Types and constants shared by the pattern cell delta packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdp_pkg;

    localparam int FIELD_COUNT    = 6;
    localparam int BYTE_W         = 8;
    localparam int CELL_W         = FIELD_COUNT * BYTE_W;
    localparam int NUM_SLOTS      = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;
    localparam int CHAN_FLAG_BIT  = 7;

    // byte slots of one transaction's output, in emit order
    localparam int SLOT_CHAN      = 0;
    localparam int SLOT_MASK      = 1;
    localparam int SLOT_FIELD0    = 2;
    localparam int SLOT_ROW_END   = 8;

    // diff-mask bit positions
    localparam int FLD_NOTE       = 0;
    localparam int FLD_INSTRUMENT = 1;
    localparam int FLD_VOL_CMD    = 2;
    localparam int FLD_VOL_VAL    = 3;
    localparam int FLD_FX_CMD     = 4;
    localparam int FLD_FX_PARAM   = 5;

    localparam logic [7:0] PC_NOTE_RESET        = 8'd252;
    localparam logic [7:0] PC_SMOOTH_NOTE_RESET = 8'd251;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PC_NOTE        = 1'b0,
        CFG_PC_SMOOTH_NOTE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [5:0] channel;
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] volume_command;
        logic [7:0] volume_value;
        logic [7:0] effect_command;
        logic [7:0] effect_param;
        logic       row_end;
        logic       pattern_start;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_t;

    typedef logic [FIELD_COUNT-1:0][BYTE_W-1:0] cell_t;

    typedef struct packed {
        logic [7:0]             chan_byte;
        logic [FIELD_COUNT-1:0] mask;
        cell_t                  fields;
        logic                   kept;
        logic                   row_end;
    } pack_t;

endpackage

`default_nettype wire

/* src/pcdp_ram.sv */
// ----------------------------------------------------------------------------
// pcdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/pcdp_diff.sv */
// ----------------------------------------------------------------------------
// pcdp_diff
// Cell stage: reads the channel's last cell, compares, writes back and
// keeps the per-channel valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_diff #(
    parameter int CHANNELS = 64,
    parameter int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire pcdp_pkg::in_t   s_data,
    input  wire logic [7:0]      pc_note,
    input  wire logic [7:0]      pc_smooth_note,
    output logic                 pk_valid,
    input  wire logic            pk_ready,
    output pcdp_pkg::pack_t      pk_data
);

    logic                  st_valid_reg;
    pcdp_pkg::in_t         st_item_reg;
    logic                  fwd_hit_reg, fwd_hit_next;
    pcdp_pkg::cell_t       fwd_cell_reg;
    logic [CHANNELS-1:0]   valid_reg, valid_next;
    logic [pcdp_pkg::CELL_W-1:0] rd_data;
    pcdp_pkg::cell_t       cur_cell, prev_cell;
    logic [CW-1:0]         st_addr, s_addr;
    logic                  in_range, kept, changed, ch_valid, advance, accept;
    logic [pcdp_pkg::FIELD_COUNT-1:0] mask;
    logic [7:0]            ch_plus;

    assign st_addr  = st_item_reg.channel[CW-1:0];
    assign s_addr   = s_data.channel[CW-1:0];
    assign advance  = st_valid_reg && pk_ready;
    assign s_ready  = !st_valid_reg || advance;
    assign accept   = s_valid && s_ready;

    always_comb begin
        cur_cell[pcdp_pkg::FLD_NOTE]       = st_item_reg.note;
        cur_cell[pcdp_pkg::FLD_INSTRUMENT] = st_item_reg.instrument;
        cur_cell[pcdp_pkg::FLD_VOL_CMD]    = st_item_reg.volume_command;
        cur_cell[pcdp_pkg::FLD_VOL_VAL]    = st_item_reg.volume_value;
        cur_cell[pcdp_pkg::FLD_FX_CMD]     = st_item_reg.effect_command;
        cur_cell[pcdp_pkg::FLD_FX_PARAM]   = st_item_reg.effect_param;

        in_range = 7'(st_item_reg.channel) < 7'(CHANNELS);
        kept     = in_range && ((st_item_reg.note == pc_note) ||
                                (st_item_reg.note == pc_smooth_note));
        ch_valid = in_range && !st_item_reg.pattern_start && valid_reg[st_addr];

        if (!ch_valid) begin
            prev_cell = '0;
        end else if (fwd_hit_reg) begin
            prev_cell = fwd_cell_reg;
        end else begin
            prev_cell = pcdp_pkg::cell_t'(rd_data);
        end

        for (int i = 0; i < pcdp_pkg::FIELD_COUNT; i++) begin
            mask[i] = prev_cell[i] != cur_cell[i];
        end
        changed = kept && (mask != '0);

        ch_plus = 8'(st_item_reg.channel) + 8'd1;
        pk_data.chan_byte = ch_plus;
        pk_data.chan_byte[pcdp_pkg::CHAN_FLAG_BIT] = changed;
        pk_data.mask      = changed ? mask : '0;
        pk_data.fields    = cur_cell;
        pk_data.kept      = kept;
        pk_data.row_end   = st_item_reg.row_end;

        valid_next = valid_reg;
        if (advance) begin
            if (st_item_reg.pattern_start) begin
                valid_next = '0;
            end
            if (changed) begin
                valid_next[st_addr] = 1'b1;
            end
        end

        // same-edge write to the entry being read: take the written cell
        fwd_hit_next = advance && changed && (st_addr == s_addr);
    end

    assign pk_valid = st_valid_reg;

    pcdp_ram #(
        .WIDTH (pcdp_pkg::CELL_W),
        .DEPTH (CHANNELS),
        .AW    (CW)
    ) u_last_cell (
        .aclk  (aclk),
        .we    (advance && changed),
        .waddr (st_addr),
        .wdata (cur_cell),
        .re    (accept),
        .raddr (s_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            valid_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                st_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_item_reg  <= s_data;
            fwd_cell_reg <= cur_cell;
        end
    end

endmodule

`default_nettype wire

/* src/pcdp_serial.sv */
// ----------------------------------------------------------------------------
// pcdp_serial
// Byte serializer: emits one transaction's bytes in order through an
// output register, one byte per cycle unless m_ready stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_serial (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              pk_valid,
    output logic                   pk_ready,
    input  wire pcdp_pkg::pack_t   pk_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pcdp_pkg::out_t         m_data
);

    logic [pcdp_pkg::NUM_SLOTS-1:0] pend_reg, pend_next, pend_left, sel;
    pcdp_pkg::pack_t                hold_reg;
    logic                           out_valid_reg;
    pcdp_pkg::out_t                 out_reg, out_next;
    logic                           emit, load;
    logic [pcdp_pkg::NUM_SLOTS-1:0] new_pend;

    always_comb begin
        emit = (pend_reg != '0) && (!out_valid_reg || m_ready);

        sel = '0;
        for (int i = pcdp_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = '0;
                sel[i] = 1'b1;
            end
        end

        pend_left = emit ? (pend_reg & ~sel) : pend_reg;
        pk_ready  = pend_left == '0;
        load      = pk_valid && pk_ready;

        new_pend = '0;
        new_pend[pcdp_pkg::SLOT_CHAN] = pk_data.kept;
        new_pend[pcdp_pkg::SLOT_MASK] = pk_data.mask != '0;
        for (int i = 0; i < pcdp_pkg::FIELD_COUNT; i++) begin
            new_pend[pcdp_pkg::SLOT_FIELD0 + i] = pk_data.mask[i];
        end
        new_pend[pcdp_pkg::SLOT_ROW_END] = pk_data.row_end;

        pend_next = load ? new_pend : pend_left;

        out_next.out_byte = '0;
        for (int i = 0; i < pcdp_pkg::FIELD_COUNT; i++) begin
            if (sel[pcdp_pkg::SLOT_FIELD0 + i]) begin
                out_next.out_byte = hold_reg.fields[i];
            end
        end
        if (sel[pcdp_pkg::SLOT_CHAN]) begin
            out_next.out_byte = hold_reg.chan_byte;
        end
        if (sel[pcdp_pkg::SLOT_MASK]) begin
            out_next.out_byte = 8'(hold_reg.mask);
        end
        out_next.last_byte = (pend_reg & ~sel) == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= pk_data;
        end
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* src/pattern_cell_delta_packer_core.sv */
// ----------------------------------------------------------------------------
// pattern_cell_delta_packer_core
// Packs pattern cells into a delta-coded byte stream against the last cell
// stored per channel.
//
//   channel   dir  ports                        transaction
//   s_        in   s_valid s_ready s_data       one pattern cell
//   m_        out  m_valid m_ready m_data       one packed byte
//   cfg_      in   cfg_we cfg_index cfg_wdata   one register write
//
// A cell yields 0 to 9 output bytes; the output port takes one byte per cycle
// while m_ready is high, and the next cell waits in the diff stage meanwhile.
// The first byte passes the diff stage, hold and output registers in order.
// The last-cell RAM needs no clear after reset; per-channel valid flops
// reset and pattern_start clear at once.
// A stalled m_ready holds the output register and backs up into s_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_cell_delta_packer_core #(
    parameter int CHANNELS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire pcdp_pkg::in_t                     s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output pcdp_pkg::out_t                         m_data,
    input  wire logic                              cfg_we,
    input  wire logic [pcdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcdp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [7:0]      pc_note_reg, pc_smooth_note_reg;
    logic            pk_valid, pk_ready;
    pcdp_pkg::pack_t pk_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_note_reg        <= pcdp_pkg::PC_NOTE_RESET;
            pc_smooth_note_reg <= pcdp_pkg::PC_SMOOTH_NOTE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                pcdp_pkg::CFG_PC_NOTE:        pc_note_reg        <= cfg_wdata;
                pcdp_pkg::CFG_PC_SMOOTH_NOTE: pc_smooth_note_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pcdp_diff #(
        .CHANNELS (CHANNELS)
    ) u_diff (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .pc_note        (pc_note_reg),
        .pc_smooth_note (pc_smooth_note_reg),
        .pk_valid       (pk_valid),
        .pk_ready       (pk_ready),
        .pk_data        (pk_data)
    );

    pcdp_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pk_valid (pk_valid),
        .pk_ready (pk_ready),
        .pk_data  (pk_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
